### hdl/htfd_pkg.sv
// Shared constants, types and the CRC-8 step of the humidity/temperature frame decoder.
package htfd_pkg;

    typedef logic [2:0] t_pos;

    // Byte positions within one measurement frame
    localparam t_pos POS_T_MSB = 3'd0;
    localparam t_pos POS_T_LSB = 3'd1;
    localparam t_pos POS_T_CRC = 3'd2;
    localparam t_pos POS_H_MSB = 3'd3;
    localparam t_pos POS_H_LSB = 3'd4;
    localparam t_pos POS_H_CRC = 3'd5;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [10:0] TEMP_SCALE  = 11'd1750;
    localparam logic signed [11:0] TEMP_OFFSET = -12'sd450;
    localparam logic [6:0]  HUM_SCALE   = 7'd100;
    localparam logic [22:0] HUM_ROUND   = 23'd32768;

    typedef logic signed [11:0] t_temp;
    typedef logic [6:0]         t_hum;

    // One byte of CRC-8, MSB first, no final xor
    function automatic logic [7:0] htfd_crc8(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hdl/htfd_conv.sv
// Scaling of the raw temperature and humidity words into tenths of a degree and percent.
module htfd_conv
    import htfd_pkg::*;
(
    input  logic [15:0] i_temp_word,
    input  logic [15:0] i_hum_word,
    output t_temp       o_temp_tenths,
    output t_hum        o_hum_percent
);

    logic [26:0] temp_prod;
    logic [22:0] hum_prod;

    always_comb begin
        temp_prod = 27'(i_temp_word) * 27'(TEMP_SCALE);
        // Round humidity to the nearest percent
        hum_prod  = 23'(i_hum_word) * 23'(HUM_SCALE) + HUM_ROUND;
        o_temp_tenths = t_temp'({1'b0, temp_prod[26:16]}) + TEMP_OFFSET;
        o_hum_percent = hum_prod[22:16];
    end

endmodule

### hdl/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature measurement frame decoder.
// Takes one frame byte per word (temperature MSB, LSB, CRC, then humidity MSB, LSB, CRC)
// and, on the sixth byte, delivers one result word with temperature in tenths of a degree,
// humidity in whole percent and a CRC status (0 ok, 1 mismatch, values forced to 0).
// A byte is accepted every cycle, except while a sixth byte sits in the input register
// behind a result that i_stall holds. The input register takes a sixth byte when it is
// accepted, and the result register behind the combinational CRC and scaling logic takes
// the reading when that byte leaves the input register, which i_stall can delay.
// i_frame_start restarts the frame and drops a partial one.
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_stall,
    output t_temp       o_temperature_tenths,
    output t_hum        o_humidity_percent,
    output logic        o_status
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    t_pos        r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp_word, n_temp_word;
    logic [15:0] r_hum_word, n_hum_word;
    logic        r_temp_ok, n_temp_ok;

    logic        r_out_vld;
    t_temp       r_out_temp;
    t_hum        r_out_hum;
    logic        r_out_status;

    t_pos        eff_pos;
    logic [7:0]  crc_cur;
    logic [7:0]  crc_step;
    logic        s1_last;
    logic        s1_fire;
    logic        in_accept;
    logic        frame_ok;
    t_temp       conv_temp;
    t_hum        conv_hum;

    htfd_conv u_conv (
        .i_temp_word   (r_temp_word),
        .i_hum_word    (r_hum_word),
        .o_temp_tenths (conv_temp),
        .o_hum_percent (conv_hum)
    );

    always_comb begin
        if (r_in_start || r_pos > POS_H_CRC) begin
            eff_pos = POS_T_MSB;
        end else begin
            eff_pos = r_pos;
        end
        crc_cur  = r_in_start ? CRC_INIT : r_crc;
        crc_step = htfd_crc8(crc_cur, r_in_byte);
        s1_last  = (eff_pos == POS_H_CRC);
        // Only a frame-closing word must wait for the result register
        s1_fire  = r_in_vld && (!s1_last || !r_out_vld || !i_stall);
        frame_ok = r_temp_ok && (crc_cur == r_in_byte);

        n_pos       = t_pos'(eff_pos + 3'd1);
        n_crc       = crc_step;
        n_temp_word = r_temp_word;
        n_hum_word  = r_hum_word;
        n_temp_ok   = r_temp_ok;
        case (eff_pos)
            POS_T_MSB: begin
                n_temp_word = {r_in_byte, r_temp_word[7:0]};
            end
            POS_T_LSB: begin
                n_temp_word = {r_temp_word[15:8], r_in_byte};
            end
            POS_T_CRC: begin
                n_temp_ok = (crc_cur == r_in_byte);
                n_crc     = CRC_INIT;
            end
            POS_H_MSB: begin
                n_hum_word = {r_in_byte, r_hum_word[7:0]};
            end
            POS_H_LSB: begin
                n_hum_word = {r_hum_word[15:8], r_in_byte};
            end
            default: begin
                n_pos = POS_T_MSB;
                n_crc = CRC_INIT;
            end
        endcase
    end

    assign o_stall   = r_in_vld && !s1_fire;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_pos       <= POS_T_MSB;
            r_crc       <= CRC_INIT;
            r_temp_word <= '0;
            r_hum_word  <= '0;
            r_temp_ok   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (s1_fire) begin
                r_in_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_pos       <= n_pos;
                r_crc       <= n_crc;
                r_temp_word <= n_temp_word;
                r_hum_word  <= n_hum_word;
                r_temp_ok   <= n_temp_ok;
            end
            if (s1_fire && s1_last) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_frame_start;
        end
        if (s1_fire && s1_last) begin
            r_out_temp   <= frame_ok ? conv_temp : '0;
            r_out_hum    <= frame_ok ? conv_hum : '0;
            r_out_status <= !frame_ok;
        end
    end

    assign o_valid              = r_out_vld;
    assign o_temperature_tenths = r_out_temp;
    assign o_humidity_percent   = r_out_hum;
    assign o_status             = r_out_status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_status |-> r_out_temp == '0 && r_out_hum == '0)
        else $error("error result carries nonzero values");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_hum <= HUM_SCALE)
        else $error("humidity above full scale");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_H_CRC)
        else $error("byte position past frame end");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && s1_last |=> r_pos == POS_T_MSB && r_crc == CRC_INIT && r_out_vld)
        else $error("frame end did not restart frame or post result");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld && r_out_vld && i_stall)
        else $error("input stalled without a blocked result");

endmodule
